// File: hdl/bmf_pkg.sv
// Shared constants, codes, types and helpers of the block-mapped flash translation controller.
package bmf_pkg;

	// Geometry: pages per block is a power of two, so the sector number splits by bit slicing
	localparam int PAGE_W        = 5;
	localparam int PAGES_PER_BLK = 1 << PAGE_W;
	localparam int NUM_BLOCKS    = 64;
	localparam int BLK_W         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int DATA_BLOCKS   = NUM_BLOCKS - 1;

	// Field widths
	localparam int LSN_W  = 11;
	localparam int ADDR_W = 11;
	localparam int CMD_W  = 3;
	localparam int STS_W  = 2;

	// Flash command codes
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_COPY_RD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COPY_WR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_NONE    = 3'd5;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_UNMAPPED = 2'd1;
	localparam logic [STS_W-1:0] STS_NO_FREE  = 2'd2;

	// Controller states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_SCAN,
		S_NOFREE,
		S_NEWWR,
		S_ROWRD,
		S_COPY,
		S_WRSP,
		S_ERASE
	} state_t;

	// Which result the output register loads
	typedef enum logic [2:0] {
		EM_READ,
		EM_UNMAP,
		EM_NOFREE,
		EM_WR_NEW,
		EM_WR_OLD,
		EM_COPY,
		EM_WR_SPARE,
		EM_ERASE
	} emit_t;

	// Controller to datapath
	typedef struct packed {
		logic  load;
		logic  clr_en;
		logic  row_rd;
		logic  scan_start;
		logic  scan_step;
		logic  map_new;
		logic  wr_old;
		logic  wr_spare;
		logic  copy_start;
		logic  copy_step;
		logic  commit;
		logic  emit;
		emit_t kind;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_write;
		logic in_range;
		logic mapped;
		logic page_wr;
		logic scan_hit;
		logic scan_end;
		logic copy_skip;
		logic copy_done;
		logic out_free;
	} dp_stat_t;

	// Physical page number of a page in a block, cut to the address field
	function automatic logic [ADDR_W-1:0] page_addr(input logic [BLK_W-1:0] blk,
			input logic [PAGE_W-1:0] pg);
		logic [BLK_W+PAGE_W-1:0] full;
		full = {blk, pg};
		return ADDR_W'(full);
	endfunction

endpackage

// File: hdl/bmf_req_if.sv
// Request channel: action and logical sector number under a valid/ready handshake.
interface bmf_req_if import bmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [LSN_W-1:0] lsn;

	modport source (output valid, output action, output lsn, input ready);
	modport sink (input valid, input action, input lsn, output ready);
endinterface

// File: hdl/bmf_cmd_if.sv
// Flash command channel: command, address, status and last under a valid/ready handshake.
interface bmf_cmd_if import bmf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	logic [STS_W-1:0]  status;
	logic              last;

	modport source (output valid, output command, output address, output status, output last,
		input ready);
	modport sink (input valid, input command, input address, input status, input last,
		output ready);
endinterface

// File: hdl/bmf_ctrl.sv
// Controller state machine: sequences lookup, free-block scan, copy pass and erase.
module bmf_ctrl import bmf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (!stat.is_write) begin
					if (stat.out_free) state_d = S_IDLE;
				end else if (stat.mapped) begin
					state_d = S_ROWRD;
				end else if (stat.in_range) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_NOFREE;
				end
			end
			S_SCAN: begin
				if (stat.scan_hit) state_d = S_NEWWR;
				else if (stat.scan_end) state_d = S_NOFREE;
			end
			S_NOFREE, S_NEWWR: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			S_ROWRD: begin
				if (stat.page_wr) state_d = S_COPY;
				else if (stat.out_free) state_d = S_IDLE;
			end
			S_COPY: begin
				if (stat.copy_done && (stat.copy_skip || stat.out_free)) state_d = S_WRSP;
			end
			S_WRSP: begin
				if (stat.out_free) state_d = S_ERASE;
			end
			S_ERASE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl       = '0;
		ctl.kind  = EM_READ;
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_en = 1'b1;
			end
			S_IDLE: begin
				ctl.load = req_valid;
			end
			S_LOOKUP: begin
				if (!stat.is_write) begin
					ctl.emit = stat.out_free;
					ctl.kind = stat.mapped ? EM_READ : EM_UNMAP;
				end else if (stat.mapped) begin
					ctl.row_rd = 1'b1;
				end else if (stat.in_range) begin
					ctl.scan_start = 1'b1;
				end
			end
			S_SCAN: begin
				ctl.scan_step = !stat.scan_hit && !stat.scan_end;
			end
			S_NOFREE: begin
				ctl.emit = stat.out_free;
				ctl.kind = EM_NOFREE;
			end
			S_NEWWR: begin
				ctl.emit    = stat.out_free;
				ctl.kind    = EM_WR_NEW;
				ctl.map_new = stat.out_free;
			end
			S_ROWRD: begin
				if (stat.page_wr) begin
					ctl.wr_spare   = 1'b1;
					ctl.copy_start = 1'b1;
				end else begin
					ctl.emit   = stat.out_free;
					ctl.kind   = EM_WR_OLD;
					ctl.wr_old = stat.out_free;
				end
			end
			S_COPY: begin
				// skip the target page; otherwise move on only when a result goes out
				ctl.kind      = EM_COPY;
				ctl.emit      = !stat.copy_skip && stat.out_free;
				ctl.copy_step = stat.copy_skip || stat.out_free;
			end
			S_WRSP: begin
				ctl.emit = stat.out_free;
				ctl.kind = EM_WR_SPARE;
			end
			S_ERASE: begin
				ctl.emit   = stat.out_free;
				ctl.kind   = EM_ERASE;
				ctl.commit = stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// File: hdl/bmf_dpath.sv
// Datapath: block map, valid and used bits, written-page rows, counters and output register.
module bmf_dpath import bmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          ctl,
	output dp_stat_t          stat,
	input  logic              req_action,
	input  logic [LSN_W-1:0]  req_lsn,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CMD_W-1:0]  out_command,
	output logic [ADDR_W-1:0] out_address,
	output logic [STS_W-1:0]  out_status,
	output logic              out_last
);

	// Request registers
	logic             action_q;
	logic [LSN_W-1:0] lsn_q;

	// Mapping state
	logic [BLK_W-1:0]       bmap_mem [DATA_BLOCKS];
	logic [BLK_W-1:0]       bmap_rd_q;
	logic [DATA_BLOCKS-1:0] map_valid_q;
	logic [NUM_BLOCKS-1:0]  used_q;
	logic [BLK_W-1:0]       spare_q;
	logic [NUM_BLOCKS-1:0]  used_set;
	logic [NUM_BLOCKS-1:0]  used_clr;

	// Written bits, one row per physical block
	logic [PAGES_PER_BLK-1:0] row_mem [NUM_BLOCKS];
	logic [PAGES_PER_BLK-1:0] row_q;
	logic [PAGES_PER_BLK-1:0] row_wdata;
	logic [BLK_W-1:0]         row_waddr;
	logic                     row_we;

	// Counters
	logic [BLK_W-1:0]  clr_q;
	logic [BLK_W-1:0]  scan_q;
	logic [PAGE_W-1:0] pg_q;
	logic              ph_q;

	// Output register
	logic              out_valid_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [STS_W-1:0]  sts_q;
	logic              last_q;
	logic [CMD_W-1:0]  cmd_d;
	logic [ADDR_W-1:0] addr_d;
	logic [STS_W-1:0]  sts_d;
	logic              last_d;

	// Decoded request
	logic [LSN_W-1:0]         lbn_full;
	logic [LSN_W-1:0]         in_lbn_full;
	logic [BLK_W-1:0]         idx;
	logic [BLK_W-1:0]         in_idx;
	logic                     in_range;
	logic                     in_rng_in;
	logic [PAGE_W-1:0]        off;
	logic [PAGES_PER_BLK-1:0] page_bit;

	assign lbn_full    = lsn_q >> PAGE_W;
	assign in_lbn_full = req_lsn >> PAGE_W;
	assign idx         = lbn_full[BLK_W-1:0];
	assign in_idx      = in_lbn_full[BLK_W-1:0];
	assign in_range    = lbn_full < LSN_W'(DATA_BLOCKS);
	assign in_rng_in   = in_lbn_full < LSN_W'(DATA_BLOCKS);
	assign off         = lsn_q[PAGE_W-1:0];

	// The spare becomes used and the old block is released on commit
	assign used_set = NUM_BLOCKS'(1) << spare_q;
	assign used_clr = NUM_BLOCKS'(1) << bmap_rd_q;

	always_comb begin
		page_bit      = '0;
		page_bit[off] = 1'b1;
	end

	// Request capture and block map
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			action_q <= req_action;
			lsn_q    <= req_lsn;
		end
		if (ctl.load && in_rng_in) begin
			bmap_rd_q <= bmap_mem[in_idx];
		end
		if (ctl.map_new) begin
			bmap_mem[idx] <= scan_q;
		end else if (ctl.commit) begin
			bmap_mem[idx] <= spare_q;
		end
	end

	// Control state: valid and used bits, spare, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
			used_q      <= '0;
			spare_q     <= BLK_W'(NUM_BLOCKS - 1);
			clr_q       <= '0;
			scan_q      <= '0;
			pg_q        <= '0;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_en) clr_q <= clr_q + 1'b1;
			if (ctl.scan_start) scan_q <= '0;
			else if (ctl.scan_step) scan_q <= scan_q + 1'b1;
			if (ctl.copy_start) begin
				pg_q <= '0;
				ph_q <= 1'b0;
			end else if (ctl.copy_step) begin
				if (stat.copy_skip || ph_q) begin
					pg_q <= pg_q + 1'b1;
					ph_q <= 1'b0;
				end else begin
					ph_q <= 1'b1;
				end
			end
			if (ctl.map_new) begin
				map_valid_q[idx] <= 1'b1;
				used_q[scan_q]   <= 1'b1;
			end else if (ctl.commit) begin
				used_q  <= (used_q | used_set) & ~used_clr;
				spare_q <= bmap_rd_q;
			end
			if (ctl.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Row write port
	always_comb begin
		row_we    = 1'b1;
		row_waddr = clr_q;
		row_wdata = '0;
		priority if (ctl.clr_en) begin
			row_waddr = clr_q;
			row_wdata = '0;
		end else if (ctl.map_new) begin
			row_waddr = scan_q;
			row_wdata = page_bit;
		end else if (ctl.wr_old) begin
			row_waddr = bmap_rd_q;
			row_wdata = row_q | page_bit;
		end else if (ctl.wr_spare) begin
			row_waddr = spare_q;
			row_wdata = row_q | page_bit;
		end else if (ctl.commit) begin
			row_waddr = bmap_rd_q;
			row_wdata = '0;
		end else begin
			row_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_waddr] <= row_wdata;
		if (ctl.row_rd) row_q <= row_mem[bmap_rd_q];
	end

	// Result payload
	always_comb begin
		unique case (ctl.kind)
			EM_READ: begin
				cmd_d = CMD_READ;  addr_d = page_addr(bmap_rd_q, off);
				sts_d = STS_OK;    last_d = 1'b1;
			end
			EM_UNMAP: begin
				cmd_d = CMD_NONE;  addr_d = '0;
				sts_d = STS_UNMAPPED; last_d = 1'b1;
			end
			EM_NOFREE: begin
				cmd_d = CMD_NONE;  addr_d = '0;
				sts_d = STS_NO_FREE; last_d = 1'b1;
			end
			EM_WR_NEW: begin
				cmd_d = CMD_WRITE; addr_d = page_addr(scan_q, off);
				sts_d = STS_OK;    last_d = 1'b1;
			end
			EM_WR_OLD: begin
				cmd_d = CMD_WRITE; addr_d = page_addr(bmap_rd_q, off);
				sts_d = STS_OK;    last_d = 1'b1;
			end
			EM_COPY: begin
				cmd_d  = ph_q ? CMD_COPY_WR : CMD_COPY_RD;
				addr_d = ph_q ? page_addr(spare_q, pg_q) : page_addr(bmap_rd_q, pg_q);
				sts_d  = STS_OK;
				last_d = 1'b0;
			end
			EM_WR_SPARE: begin
				cmd_d = CMD_WRITE; addr_d = page_addr(spare_q, off);
				sts_d = STS_OK;    last_d = 1'b0;
			end
			EM_ERASE: begin
				cmd_d = CMD_ERASE; addr_d = ADDR_W'(bmap_rd_q);
				sts_d = STS_OK;    last_d = 1'b1;
			end
			default: begin
				cmd_d = CMD_NONE;  addr_d = '0;
				sts_d = STS_OK;    last_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			cmd_q  <= cmd_d;
			addr_q <= addr_d;
			sts_q  <= sts_d;
			last_q <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_command = cmd_q;
	assign out_address = addr_q;
	assign out_status  = sts_q;
	assign out_last    = last_q;

	// Status to the controller
	always_comb begin
		stat.clr_done  = (clr_q == BLK_W'(NUM_BLOCKS - 1));
		stat.is_write  = action_q;
		stat.in_range  = in_range;
		stat.mapped    = in_range && map_valid_q[idx];
		stat.page_wr   = row_q[off];
		stat.scan_hit  = !used_q[scan_q] && (scan_q != spare_q);
		stat.scan_end  = (scan_q == BLK_W'(NUM_BLOCKS - 1));
		stat.copy_skip = (pg_q == off);
		stat.copy_done = (pg_q == PAGE_W'(PAGES_PER_BLK - 1)) && ((pg_q == off) || ph_q);
		stat.out_free  = !out_valid_q || out_ready;
	end

endmodule

// File: hdl/block_mapped_ftl_controller_top.sv
// Top level of the block-mapped flash translation controller: request in, flash commands out.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, lsn
//  cmd      out  valid/ready    command, address, status, last
//
// A read goes through the lookup state to the output register. A write to a free page of a mapped
// block also reads the block's written-page row; a first write to a block adds the free-block scan,
// one block per cycle. An overwrite emits 2*PAGES_PER_BLK results, one per cycle at most, through the
// copy sequencer and the single output register.
// After reset the written-page rows are cleared one row a cycle, with req held off.
// A stalled cmd holds the sequencer; the next req is taken once the last result is in the register.
module block_mapped_ftl_controller_top import bmf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	bmf_req_if.sink   req,
	bmf_cmd_if.source cmd
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// Sequence the request: lookup, scan, copy pass, erase
	bmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Hold the mapping state and drive the result register
	bmf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.req_action  (req.action),
		.req_lsn     (req.lsn),
		.out_valid   (cmd.valid),
		.out_ready   (cmd.ready),
		.out_command (cmd.command),
		.out_address (cmd.address),
		.out_status  (cmd.status),
		.out_last    (cmd.last)
	);

	// Drop ready straight after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
	else $error("request taken while the previous one is in progress");

	// Never load the result register over an item not yet taken
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!cmd.valid || cmd.ready))
	else $error("result overwritten before it was taken");

	// Refusals carry no command and end the request
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.status != STS_OK) |-> (cmd.command == CMD_NONE && cmd.last))
	else $error("error status on a real command or not last");

	// The erase closes an overwrite
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.command == CMD_ERASE) |-> cmd.last)
	else $error("erase not marked last");

endmodule

// File: tb/block_mapped_ftl_controller_top_tb.sv
// Self-checking testbench of the block-mapped flash translation controller.
`timescale 1ns / 100ps

module block_mapped_ftl_controller_top_tb import bmf_pkg::*; ();

	// Request action codes
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Cycles with no item moving on either channel before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// Receiver hold-off used to fill the block and stall its request side
	localparam int HOLD_OFF_CYCLES = 300;
	// Settling time after the last expected command: about one overwrite
	localparam int TAIL_CYCLES = 2 * PAGES_PER_BLK + 8;
	localparam int LSN_SPAN = 1 << LSN_W;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address;
		logic [STS_W-1:0]  status;
		logic              last;
	} flash_cmd_t;

	logic clk = 1'b0;
	logic arst_n;

	bmf_req_if req_ch ();
	bmf_cmd_if cmd_ch ();

	block_mapped_ftl_controller_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cmd    (cmd_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Translation state mirrored by the testbench
	logic [BLK_W-1:0] l2p       [DATA_BLOCKS];
	logic             l2p_ok    [DATA_BLOCKS];
	logic             phys_used [NUM_BLOCKS];
	logic             page_full [NUM_BLOCKS * PAGES_PER_BLK];
	logic [BLK_W-1:0] spare_blk;

	// Flash commands still owed by the block, oldest first
	flash_cmd_t pending_cmds[$];
	flash_cmd_t due;

	int errors = 0;
	int quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int hold_off_req = 0;
	int hold_off_left = 0;

	function automatic logic [ADDR_W-1:0] page_no(input int blk, input int pg);
		return ADDR_W'(blk * PAGES_PER_BLK + pg);
	endfunction

	task automatic owe_cmd(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
			input logic [STS_W-1:0] s, input logic fin);
		flash_cmd_t item;
		item.command = c;
		item.address = a;
		item.status  = s;
		item.last    = fin;
		pending_cmds.push_back(item);
	endtask

	// Work out the flash commands one request causes and advance the mirrored state
	task automatic translate_request(input logic act, input logic [LSN_W-1:0] sn);
		int  lbn;
		int  off;
		int  found;
		int  old;
		int  nb;
		int  src;
		int  dst;
		logic hit;
		lbn = int'(sn) / PAGES_PER_BLK;
		off = int'(sn) % PAGES_PER_BLK;
		hit = (lbn < DATA_BLOCKS) ? l2p_ok[lbn] : 1'b0;

		if (act == ACT_READ) begin
			if (!hit)
				owe_cmd(CMD_NONE, '0, STS_UNMAPPED, 1'b1);
			else
				owe_cmd(CMD_READ, page_no(int'(l2p[lbn]), off), STS_OK, 1'b1);
			return;
		end

		// First write to a logical block: take the lowest free block other than the spare
		if (!hit) begin
			found = NUM_BLOCKS;
			if (lbn < DATA_BLOCKS)
				for (int i = 0; i < NUM_BLOCKS; i++)
					if (found == NUM_BLOCKS && !phys_used[i] && i != int'(spare_blk))
						found = i;
			if (found == NUM_BLOCKS) begin
				owe_cmd(CMD_NONE, '0, STS_NO_FREE, 1'b1);
				return;
			end
			l2p[lbn] = BLK_W'(found);
			l2p_ok[lbn] = 1'b1;
			phys_used[found] = 1'b1;
			page_full[found * PAGES_PER_BLK + off] = 1'b1;
			owe_cmd(CMD_WRITE, page_no(found, off), STS_OK, 1'b1);
			return;
		end

		old = int'(l2p[lbn]);
		if (!page_full[old * PAGES_PER_BLK + off]) begin
			page_full[old * PAGES_PER_BLK + off] = 1'b1;
			owe_cmd(CMD_WRITE, page_no(old, off), STS_OK, 1'b1);
			return;
		end

		// Overwrite: copy every other page into the spare, write the page, erase the old block
		nb = int'(spare_blk);
		for (int i = 0; i < PAGES_PER_BLK; i++) begin
			if (i != off) begin
				src = old * PAGES_PER_BLK + i;
				dst = nb * PAGES_PER_BLK + i;
				owe_cmd(CMD_COPY_RD, page_no(old, i), STS_OK, 1'b0);
				owe_cmd(CMD_COPY_WR, page_no(nb, i), STS_OK, 1'b0);
				page_full[dst] = page_full[src];
			end
		end
		page_full[nb * PAGES_PER_BLK + off] = 1'b1;
		owe_cmd(CMD_WRITE, page_no(nb, off), STS_OK, 1'b0);
		for (int i = 0; i < PAGES_PER_BLK; i++)
			page_full[old * PAGES_PER_BLK + i] = 1'b0;
		owe_cmd(CMD_ERASE, ADDR_W'(old), STS_OK, 1'b1);
		l2p[lbn] = BLK_W'(nb);
		phys_used[nb] = 1'b1;
		phys_used[old] = 1'b0;
		spare_blk = BLK_W'(old);
	endtask

	// Predict on every accepted request item
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			translate_request(req_ch.action, req_ch.lsn);
	end

	// Compare every accepted command item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				errors++;
				$error("unexpected item: command %0d address %0d status %0d last %0d",
					cmd_ch.command, cmd_ch.address, cmd_ch.status, cmd_ch.last);
			end else begin
				due = pending_cmds.pop_front();
				if (cmd_ch.command !== due.command) begin
					errors++;
					$error("command: expected %0d, actual %0d", due.command, cmd_ch.command);
				end
				if (cmd_ch.address !== due.address) begin
					errors++;
					$error("address: expected %0d, actual %0d", due.address, cmd_ch.address);
				end
				if (cmd_ch.status !== due.status) begin
					errors++;
					$error("status: expected %0d, actual %0d", due.status, cmd_ch.status);
				end
				if (cmd_ch.last !== due.last) begin
					errors++;
					$error("last: expected %0d, actual %0d", due.last, cmd_ch.last);
				end
			end
		end
	end

	// Receiver: drop ready at random, or hold it low for a counted stretch on request
	initial begin
		cmd_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req != 0) begin
				hold_off_left = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run when nothing has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Offer one request item and hold it until the block takes it; valid stays high afterwards
	task automatic send_item(input logic act, input logic [LSN_W-1:0] sn);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.lsn    <= sn;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Unmapped reads, sectors past the data blocks, first write, free page, overwrite at both ends
	task automatic test_corner_cases();
		send_item(ACT_READ, LSN_W'(0));
		send_item(ACT_READ, LSN_W'(LSN_SPAN - 1));
		send_item(ACT_WRITE, LSN_W'(LSN_SPAN - 1));
		send_item(ACT_WRITE, LSN_W'(DATA_BLOCKS * PAGES_PER_BLK));
		send_item(ACT_READ, LSN_W'(DATA_BLOCKS * PAGES_PER_BLK));
		send_item(ACT_WRITE, LSN_W'(0));
		send_item(ACT_READ, LSN_W'(0));
		send_item(ACT_READ, LSN_W'(1));
		send_item(ACT_WRITE, LSN_W'(1));
		send_item(ACT_WRITE, LSN_W'(0));
		send_item(ACT_READ, LSN_W'(0));
		send_item(ACT_WRITE, LSN_W'(PAGES_PER_BLK - 1));
		send_item(ACT_WRITE, LSN_W'(PAGES_PER_BLK - 1));
		send_item(ACT_WRITE, LSN_W'(DATA_BLOCKS * PAGES_PER_BLK - 1));
		send_item(ACT_READ, LSN_W'(DATA_BLOCKS * PAGES_PER_BLK - 1));
		send_item(ACT_WRITE, LSN_W'(DATA_BLOCKS * PAGES_PER_BLK - 1));
		send_item(ACT_READ, LSN_W'(1));
		send_item(ACT_READ, LSN_W'(DATA_BLOCKS * PAGES_PER_BLK - 2));
	endtask

	// Map every logical block, in shuffled order, so the free-block scan sees varied maps
	task automatic test_map_all_blocks();
		int order[DATA_BLOCKS];
		int j;
		int tmp;
		for (int i = 0; i < DATA_BLOCKS; i++)
			order[i] = i;
		for (int i = DATA_BLOCKS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < DATA_BLOCKS; i++)
			send_item(ACT_WRITE,
				LSN_W'(order[i] * PAGES_PER_BLK + $urandom_range(0, PAGES_PER_BLK - 1)));
	endtask

	// Fill part of one block, then overwrite its first and last pages and read them back
	task automatic test_overwrite_mix();
		int base;
		base = 5 * PAGES_PER_BLK;
		for (int i = 0; i < 8; i++)
			send_item(ACT_WRITE, LSN_W'(base + $urandom_range(0, PAGES_PER_BLK - 1)));
		send_item(ACT_WRITE, LSN_W'(base));
		send_item(ACT_WRITE, LSN_W'(base));
		send_item(ACT_WRITE, LSN_W'(base + PAGES_PER_BLK - 1));
		send_item(ACT_WRITE, LSN_W'(base + PAGES_PER_BLK - 1));
		send_item(ACT_READ, LSN_W'(base));
		send_item(ACT_READ, LSN_W'(base + PAGES_PER_BLK - 1));
	endtask

	// Hold the receiver off while requests keep coming, so the block fills and stalls its input
	task automatic test_backpressure();
		int unsigned saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		hold_off_req = HOLD_OFF_CYCLES;
		for (int i = 0; i < 12; i++)
			send_item((i % 3 == 2) ? ACT_READ : ACT_WRITE,
				LSN_W'(PAGES_PER_BLK + (i % 4)));
		send_idle_pct = saved_idle;
	endtask

	// Mostly writes to a few hot blocks so overwrites dominate; the rest is reads and stray sectors
	task automatic test_random_traffic(input int count);
		int unsigned roll;
		int lbn;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			lbn = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) :
				$urandom_range(0, DATA_BLOCKS - 1);
			if (roll < 50)
				send_item(ACT_WRITE,
					LSN_W'(lbn * PAGES_PER_BLK + $urandom_range(0, PAGES_PER_BLK - 1)));
			else if (roll < 80)
				send_item(ACT_READ,
					LSN_W'(lbn * PAGES_PER_BLK + $urandom_range(0, PAGES_PER_BLK - 1)));
			else if (roll < 90)
				send_item(ACT_READ, LSN_W'($urandom_range(0, LSN_SPAN - 1)));
			else if (roll < 95)
				send_item(ACT_WRITE, LSN_W'($urandom_range(0, LSN_SPAN - 1)));
			else
				send_item(logic'($urandom_range(0, 1)),
					LSN_W'($urandom_range(DATA_BLOCKS * PAGES_PER_BLK, LSN_SPAN - 1)));
		end
	endtask

	initial begin
		// Drive every input to a known value and hold reset
		arst_n = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = ACT_READ;
		req_ch.lsn    = '0;
		for (int i = 0; i < DATA_BLOCKS; i++) begin
			l2p[i] = '0;
			l2p_ok[i] = 1'b0;
		end
		for (int i = 0; i < NUM_BLOCKS; i++)
			phys_used[i] = 1'b0;
		for (int i = 0; i < NUM_BLOCKS * PAGES_PER_BLK; i++)
			page_full[i] = 1'b0;
		spare_blk = BLK_W'(NUM_BLOCKS - 1);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phase one: sender idles lightly, receiver heavily
		send_idle_pct = 31;
		recv_idle_pct = 78;
		test_corner_cases();
		test_map_all_blocks();
		test_overwrite_mix();
		test_backpressure();

		// Phase two: the other way round
		send_idle_pct = 78;
		recv_idle_pct = 31;
		test_random_traffic(112);

		// Phase three: no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(112);

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// Drain: the watchdog bounds this wait
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
